// File: src/rsq_pkg.sv
// shared types and constants for the sequence resequencer
package rsq_pkg;

  localparam int SEQ_W       = 24;
  localparam int WINDOW      = 32;
  localparam int MAP_W       = WINDOW;
  localparam int DIST_W      = $clog2(WINDOW);
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int LIMIT_W     = 8;
  localparam int IDLE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = SEQ_W;

  localparam logic [SEQ_W-1:0]   START_RESET = {SEQ_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);
  localparam logic [IDLE_W-1:0]  IDLE_MAX    = {IDLE_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_LAST    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STORE,
    ST_RUN
  } state_t;

  // commands from the sequencer to the tracker
  typedef struct packed {
    logic load;
    logic store;
    logic shift;
  } trk_cmd_t;

  // tracker status back to the sequencer
  typedef struct packed {
    logic             store_hit;
    logic             next;
    logic [SEQ_W-1:0] rel_seq;
  } trk_stat_t;

endpackage

// File: src/rsq_ifs.sv
// valid/ready channel interfaces for arrivals and releases
interface rsq_in_if import rsq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_in;

  modport source (output valid, output seq_in, input ready);
  modport sink   (input valid, input seq_in, output ready);
endinterface

interface rsq_out_if import rsq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_out;
  logic             last_of_run;

  modport source (output valid, output seq_out, output last_of_run, input ready);
  modport sink   (input valid, input seq_out, input last_of_run, output ready);
endinterface

// File: src/rsq_track.sv
// window tracker: last released number, present map and idle counter
module rsq_track import rsq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  trk_cmd_t           cmd,
  input  logic [SEQ_W-1:0]   load_value,
  input  logic [SEQ_W-1:0]   seq,
  input  logic [LIMIT_W-1:0] limit,
  output trk_stat_t          stat
);

  logic [SEQ_W-1:0]  last;
  logic [MAP_W-1:0]  map;
  logic [IDLE_W-1:0] idle;

  logic [SEQ_W-1:0]  inc;
  logic              skip;
  logic [SEQ_W-1:0]  offset;
  logic              hit;
  logic [MAP_W-1:0]  map_skip;
  logic [MAP_W-1:0]  map_store;
  logic [IDLE_W-1:0] idle_base;
  logic [IDLE_W-1:0] idle_inc;
  logic [IDLE_W-1:0] idle_store;

  // shared incrementer: expected number, also the released number
  assign inc = last + SEQ_W'(1);

  // timeout skip, then offset of the arrival from the expected number
  assign skip     = (idle >= limit);
  assign offset   = seq - inc - SEQ_W'(skip);
  assign hit      = (offset < SEQ_W'(WINDOW));
  assign map_skip = skip ? (map >> 1) : map;
  assign map_store = hit ? (map_skip | (MAP_W'(1) << offset[DIST_W-1:0])) : map_skip;

  // idle count after the arrival: one if a release follows
  assign idle_base  = skip ? '0 : idle;
  assign idle_inc   = (idle_base == IDLE_MAX) ? idle_base : idle_base + IDLE_W'(1);
  assign idle_store = map_store[0] ? IDLE_W'(1) : idle_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= START_RESET;
      map  <= '0;
      idle <= '0;
    end else if (cmd.load) begin
      last <= load_value;
      map  <= '0;
      idle <= '0;
    end else if (cmd.store) begin
      last <= skip ? inc : last;
      map  <= map_store;
      idle <= idle_store;
    end else if (cmd.shift) begin
      last <= inc;
      map  <= map >> 1;
    end
  end

  assign stat.store_hit = map_store[0];
  assign stat.next      = map[1];
  assign stat.rel_seq   = inc;

endmodule

// File: src/sequence_resequencer_with_timeout_core.sv
// Sequence resequencer: takes 24-bit sequence numbers in any order and releases
// them in ascending modular order, one word per cycle on the release channel
// while it is not stalled. An arrival is registered and then stored in the
// window map; when it completes a run of n numbers (n at most 32), the run is
// emitted one number a cycle by the shared incrementer and window shift,
// holding while the release channel stalls, and no arrival is taken until the
// run is done. When timeout_limit arrivals pass without a release, the missing
// expected number is skipped before the next arrival is stored. Stale, duplicate
// and out-of-window numbers are dropped. Writing start_last reloads the state.
module sequence_resequencer_with_timeout_core import rsq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  rsq_in_if.sink                arrivals,
  rsq_out_if.source             releases,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t             state;
  state_t             state_next;
  logic [SEQ_W-1:0]   seq_q;
  logic [LIMIT_W-1:0] limit;
  logic [CNT_W-1:0]   count;
  logic               out_valid;
  logic [SEQ_W-1:0]   out_seq;
  logic               out_last;

  trk_cmd_t           cmd;
  trk_stat_t          stat;
  logic               slot_free;
  logic               rel_last;
  logic               accept;

  assign accept    = arrivals.valid && arrivals.ready;
  assign slot_free = !out_valid || releases.ready;
  assign rel_last  = !stat.next || (count == CNT_W'(MAX_RESULTS - 1));

  rsq_track u_track (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .load_value (cfg_data[SEQ_W-1:0]),
    .seq        (seq_q),
    .limit      (limit),
    .stat       (stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_STORE;
      ST_STORE: state_next = stat.store_hit ? ST_RUN : ST_IDLE;
      ST_RUN:   if (slot_free && rel_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    arrivals.ready = 1'b0;
    cmd.load       = cfg_we && (cfg_index == REG_START_LAST);
    cmd.store      = 1'b0;
    cmd.shift      = 1'b0;
    case (state)
      ST_IDLE:  arrivals.ready = 1'b1;
      ST_STORE: cmd.store = 1'b1;
      ST_RUN:   cmd.shift = slot_free;
      default:  arrivals.ready = 1'b0;
    endcase
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      limit <= LIMIT_RESET;
    end else begin
      state <= state_next;
      if (cfg_we && (cfg_index == REG_TIMEOUT_LIMIT)) begin
        limit <= cfg_data[LIMIT_W-1:0];
      end
    end
  end

  // arriving word and run length
  always_ff @(posedge clk) begin
    if (accept) begin
      seq_q <= arrivals.seq_in;
    end
    if (cmd.store) begin
      count <= '0;
    end else if (cmd.shift) begin
      count <= count + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.shift) begin
      out_valid <= 1'b1;
    end else if (releases.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      out_seq  <= stat.rel_seq;
      out_last <= rel_last;
    end
  end

  assign releases.valid       = out_valid;
  assign releases.seq_out     = out_seq;
  assign releases.last_of_run = out_last;

endmodule

// File: src/rsq_checker.sv
// port-level checks for the sequence resequencer, bound to the top level
module rsq_checker import rsq_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SEQ_W-1:0] seq_out,
  input logic             last_of_run
);

  // a stalled release word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(seq_out) && $stable(last_of_run))
    else $error("release word changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("release valid after reset");

  // an accepted arrival blocks the next one while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("arrival taken while busy");

  // a run continues with the next number in the next cycle
  a_run_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=>
      out_valid && (seq_out == $past(seq_out) + SEQ_W'(1)))
    else $error("release run broken");

endmodule

bind sequence_resequencer_with_timeout_core rsq_checker u_rsq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (arrivals.valid),
  .in_ready    (arrivals.ready),
  .out_valid   (releases.valid),
  .out_ready   (releases.ready),
  .seq_out     (releases.seq_out),
  .last_of_run (releases.last_of_run)
);

// File: test/tb_top.sv
// self-checking testbench for the sequence resequencer with timeout skip
module tb_top import rsq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 1500;

  // one released word as the block should present it
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             last_of_run;
  } release_word_t;

  // reorder predictor plus queue of releases still owed by the block
  class reorder_scoreboard;
    logic [SEQ_W-1:0]   start_last;
    logic [LIMIT_W-1:0] timeout_limit;
    logic [SEQ_W-1:0]   last_released;
    logic [MAP_W-1:0]   present_map;
    logic [IDLE_W-1:0]  idle_arrivals;
    release_word_t      owed_releases[$];
    int                 errors;

    function new();
      start_last    = START_RESET;
      timeout_limit = LIMIT_RESET;
      errors        = 0;
      reload();
    endfunction

    function void reload();
      last_released = start_last;
      present_map   = '0;
      idle_arrivals = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_START_LAST) begin
        start_last = data[SEQ_W-1:0];
        reload();
      end else if (idx == REG_TIMEOUT_LIMIT) begin
        timeout_limit = data[LIMIT_W-1:0];
      end
    endfunction

    function logic [SEQ_W-1:0] expected_seq();
      return last_released + SEQ_W'(1);
    endfunction

    function int pending();
      return owed_releases.size();
    endfunction

    // timeout skip, mark arrival, then release the run from the expected number
    function void note_arrival(logic [SEQ_W-1:0] seq);
      logic [SEQ_W-1:0] offset;
      release_word_t    w;
      int               run_len;
      int               i;
      if (idle_arrivals >= IDLE_W'(timeout_limit)) begin
        last_released = last_released + SEQ_W'(1);
        present_map   = present_map >> 1;
        idle_arrivals = '0;
      end
      offset = seq - (last_released + SEQ_W'(1));
      if (offset < SEQ_W'(WINDOW))
        present_map[offset[DIST_W-1:0]] = 1'b1;
      run_len = 0;
      while (run_len < MAX_RESULTS && run_len < MAP_W && present_map[run_len])
        run_len++;
      for (i = 0; i < run_len; i++) begin
        last_released = last_released + SEQ_W'(1);
        w.seq         = last_released;
        w.last_of_run = (i == run_len - 1);
        owed_releases.insert(owed_releases.size(), w);
      end
      present_map = present_map >> run_len;
      if (run_len > 0)
        idle_arrivals = '0;
      if (idle_arrivals != IDLE_MAX)
        idle_arrivals = idle_arrivals + IDLE_W'(1);
    endfunction

    // compare one released word with the oldest owed release
    function void check_release(logic [SEQ_W-1:0] seq, logic last_of_run);
      release_word_t want;
      if (owed_releases.size() == 0) begin
        $display("%0t: unexpected release, actual seq_out=%h last_of_run=%b",
                 $time, seq, last_of_run);
        errors++;
        return;
      end
      want = owed_releases[0];
      owed_releases.delete(0);
      if (seq !== want.seq) begin
        $display("%0t: seq_out mismatch, expected %h actual %h", $time, want.seq, seq);
        errors++;
      end
      if (last_of_run !== want.last_of_run) begin
        $display("%0t: last_of_run mismatch on %h, expected %b actual %b",
                 $time, want.seq, want.last_of_run, last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit idling_on     = 1'b1;
  bit quiet_sender  = 1'b0;
  bit hold_request  = 1'b0;

  reorder_scoreboard sb = new();

  rsq_in_if  arr_if ();
  rsq_out_if rel_if ();

  sequence_resequencer_with_timeout_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .arrivals  (arr_if),
    .releases  (rel_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // offer one arrival word and hold it until taken, then maybe pause
  task automatic send_word(input logic [SEQ_W-1:0] seq);
    arr_if.valid  <= 1'b1;
    arr_if.seq_in <= seq;
    @(posedge clk);
    while (!arr_if.ready) @(posedge clk);
    sb.note_arrival(seq);
    if (idling_on && !quiet_sender && $urandom_range(0, 4) == 0) begin
      arr_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // shuffled block of numbers from the expected one, optionally head held to the end
  task automatic send_burst(input int n, input bit drop_one, input bit dup_one,
                            input bit head_last);
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] e;
    logic [SEQ_W-1:0] tmp;
    int               j;
    int               k;
    e = sb.expected_seq();
    for (k = head_last ? 1 : 0; k < n; k++)
      order.insert(order.size(), e + SEQ_W'(k));
    for (k = order.size() - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    if (head_last)
      order.insert(order.size(), e);
    if (drop_one && order.size() > 1)
      order.delete($urandom_range(0, order.size() - 1));
    if (dup_one)
      order.insert(order.size(), order[$urandom_range(0, order.size() - 1)]);
    foreach (order[k])
      send_word(order[k]);
  endtask

  // mostly well-formed bursts, with stale, far-ahead and noise words mixed in
  task automatic random_phase(input int goal);
    int counted;
    int mode;
    int n;
    counted = 0;
    while (counted < goal) begin
      mode         = $urandom_range(0, 15);
      quiet_sender = ($urandom_range(0, 3) == 0);
      if (mode < 12) begin
        n = $urandom_range(1, 8);
        send_burst(n, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0, 1'b0);
        counted += n;
      end else if (mode == 12) begin
        n = $urandom_range(12, 32);
        send_burst(n, 1'b0, 1'b0, 1'b1);
        counted += n;
      end else if (mode == 13) begin
        send_word(sb.expected_seq() - SEQ_W'($urandom_range(1, 40)));
      end else if (mode == 14) begin
        send_word(sb.expected_seq() + SEQ_W'($urandom_range(WINDOW, WINDOW + 64)));
      end else begin
        send_word(SEQ_W'($urandom));
      end
    end
    quiet_sender = 1'b0;
  endtask

  // let the block drain and go idle before touching registers
  task automatic settle();
    arr_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back, keeping the enable high across them
  task automatic write_config(input logic [SEQ_W-1:0] start, input logic [LIMIT_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_LAST;
    cfg_data  <= CFG_DATA_W'(start);
    @(posedge clk);
    sb.write_reg(REG_START_LAST, CFG_DATA_W'(start));
    cfg_index <= REG_TIMEOUT_LIMIT;
    cfg_data  <= CFG_DATA_W'(limit);
    @(posedge clk);
    sb.write_reg(REG_TIMEOUT_LIMIT, CFG_DATA_W'(limit));
    cfg_we    <= 1'b0;
  endtask

  // release side: check words, random short stalls, one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    rel_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rel_if.valid && rel_if.ready)
        sb.check_release(rel_if.seq_out, rel_if.last_of_run);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rel_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rel_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 2);
        rel_if.ready <= 1'b0;
      end else begin
        rel_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (arr_if.valid && arr_if.ready) || (rel_if.valid && rel_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** sequence_resequencer_with_timeout_core: FAILED **");
    $finish;
  end

  // main sequence
  initial begin
    rst           <= 1'b1;
    arr_if.valid  <= 1'b0;
    arr_if.seq_in <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_START_LAST;
    cfg_data      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: wrap to zero, reorder, stale, duplicate, window edges
    send_word(SEQ_W'(0));
    send_word(SEQ_W'(2));
    send_word(SEQ_W'(3));
    send_word(SEQ_W'(1));
    send_word(SEQ_W'(3));
    send_word(SEQ_W'(2));
    send_word(SEQ_W'(5));
    send_word(SEQ_W'(5));
    send_word(SEQ_W'(4));
    send_word(SEQ_W'(6 + WINDOW));
    send_word(SEQ_W'(6 + WINDOW - 1));
    send_word({SEQ_W{1'b1}});
    send_word(SEQ_W'(6));

    // short timeout: missing number gets skipped near the top of the range
    settle();
    write_config(24'hfffff0, LIMIT_W'(2));
    send_word(24'hfffff3);
    send_word(24'hfffff4);
    send_word(24'hfffff5);
    send_word(24'hfffff2);
    send_word(24'hfffff6);

    // longest limit: full run across the wrap while the release side holds off
    settle();
    write_config(24'hffffe8, {LIMIT_W{1'b1}});
    hold_request = 1'b1;
    send_burst(MAX_RESULTS, 1'b0, 1'b0, 1'b1);
    random_phase(25);

    // limit of one: skip before every arrival but the first after the reload
    settle();
    write_config('0, LIMIT_W'(1));
    random_phase(20);

    // random start and mid-range limit
    settle();
    write_config(SEQ_W'($urandom), LIMIT_W'($urandom_range(3, 20)));
    random_phase(20);

    // last stretch at full rate on both sides
    settle();
    idling_on = 1'b0;
    write_config(START_RESET, LIMIT_RESET);
    random_phase(20);

    arr_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("** sequence_resequencer_with_timeout_core: PASSED **");
    else
      $display("** sequence_resequencer_with_timeout_core: FAILED **");
    $finish;
  end

endmodule

// File: sequence_resequencer_with_timeout_core.f
src/rsq_pkg.sv
src/rsq_ifs.sv
src/rsq_track.sv
src/sequence_resequencer_with_timeout_core.sv
src/rsq_checker.sv
test/tb_top.sv
